/* rtl/core/etcbf_pkg.sv */
package etcbf_pkg;

	// Fixed-point format of all pose, gain and command values.
	localparam int FRAC_BITS = 16;

	// Datapath widths.
	localparam int OP_W  = 34;
	localparam int LO_W  = OP_W / 2;
	localparam int ACC_W = 68;
	localparam int RND_W = ACC_W - FRAC_BITS;
	localparam int SUM_W = 54;
	localparam int Q_W   = 32;
	localparam int CS_W  = 18;
	localparam int ANG_W = 36;
	localparam int DIV_W = 64;

	typedef logic signed [OP_W-1:0]  op_t;
	typedef logic signed [ACC_W-1:0] acc_t;
	typedef logic signed [RND_W-1:0] rnd_t;
	typedef logic signed [SUM_W-1:0] sum_t;
	typedef logic signed [Q_W-1:0]   q_t;
	typedef logic signed [CS_W-1:0]  cs_t;
	typedef logic signed [ANG_W-1:0] ang_t;

	// Fixed-point constants.
	localparam longint ONE_Q    = longint'(1) << FRAC_BITS;
	localparam longint HALF_Q   = ONE_Q / 2;
	localparam longint GOAL_R   = ((5 * ONE_Q) + 50) / 100;
	localparam longint GOAL_SQ  = GOAL_R * GOAL_R;
	localparam longint KICK_R   = (ONE_Q + 50) / 100;
	localparam longint KICK_SQ  = KICK_R * KICK_R;
	localparam longint VMAX     = ((22 * ONE_Q) + 50) / 100;
	localparam longint WMAX     = ((284 * ONE_Q) + 50) / 100;
	localparam longint LOOK_MIN = (ONE_Q / 1000000) + 1;
	localparam longint GRAD_RAW = (ONE_Q + 500000) / 1000000;
	localparam longint GRAD_MIN = (GRAD_RAW < 1) ? 1 : GRAD_RAW;
	localparam longint SAT_LIM  = (longint'(1) << 30) - 1;

	localparam sum_t SAT_HI = sum_t'(SAT_LIM);
	localparam sum_t SAT_LO = -sum_t'(SAT_LIM);

	// Rotation CORDIC in Q2.30.
	localparam int     CORDIC_N    = 30;
	localparam int     CS_SHIFT    = 30 - FRAC_BITS;
	localparam ang_t   ANG_PI      = 36'sd3373259426;
	localparam ang_t   ANG_HALF_PI = 36'sd1686629713;
	localparam ang_t   ANG_TWO_PI  = 36'sd6746518852;
	localparam op_t    CORDIC_GAIN = 34'sh026DD3B6A;

	localparam logic [31:0] ATAN_TAB [CORDIC_N] = '{
		32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
		32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
		32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
		32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
		32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
		32'h0000001F, 32'h0000000F, 32'h00000007, 32'h00000003, 32'h00000001
	};

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_OBS_X  = 3'd0,
		REG_OBS_Y  = 3'd1,
		REG_RADIUS = 3'd2,
		REG_MARGIN = 3'd3,
		REG_LOOK   = 3'd4,
		REG_GAIN   = 3'd5
	} reg_idx_t;

	// Result status codes.
	typedef enum logic [1:0] {
		STAT_HELD   = 2'd0,
		STAT_RECOMP = 2'd1,
		STAT_GOAL   = 2'd2,
		STAT_HALT   = 2'd3
	} status_t;

	// Request to the multiply-accumulate unit.
	typedef struct packed {
		logic start;
		logic clr;
		logic sub;
	} mac_req_t;

	// Saturate to plus or minus (2^30 - 1).
	function automatic q_t sat31(input sum_t v);
		q_t r;
		if (v > SAT_HI) begin
			r = q_t'(SAT_HI);
		end else if (v < SAT_LO) begin
			r = q_t'(SAT_LO);
		end else begin
			r = q_t'(v);
		end
		return r;
	endfunction

	// Symmetric clamp to a positive limit.
	function automatic op_t clamp_lim(input op_t v, input op_t lim);
		op_t r;
		if (v > lim) begin
			r = lim;
		end else if (v < -lim) begin
			r = -lim;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

/* rtl/core/event_triggered_cbf_unicycle_top.sv */
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_ready   | pos_x, pos_y, heading
// out     | output    | out_valid/out_ready | linear_velocity, angular_velocity, status
// cfg     | input     | cfg_we             | cfg_index, cfg_data
//
// One pose at a time. The pose is worked through the shared multiply-accumulate unit,
// which takes the low then the high half of each product term, the 30-step CORDIC
// and the restoring divider, used once for a held command and once or three times
// for a recompute. The result sits in an output register, so the next pose is taken
// while it waits. Reset clears the held command and loads the register defaults.
module event_triggered_cbf_unicycle_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [23:0] pos_x,
	input  logic signed [23:0] pos_y,
	input  logic signed [18:0] heading,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [14:0] linear_velocity,
	output logic signed [18:0] angular_velocity,
	output logic [1:0]         status,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [23:0]        cfg_data
);

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_ISSUE  = 8'b0000_0010,
		S_WAIT   = 8'b0000_0100,
		S_POST   = 8'b0000_1000,
		S_CORDIC = 8'b0001_0000,
		S_DIV    = 8'b0010_0000,
		S_FIN    = 8'b0100_0000,
		S_EMIT   = 8'b1000_0000
	} state_t;

	typedef enum logic [4:0] {
		STEP_GOAL, STEP_PX, STEP_PY, STEP_PDX, STEP_PDY, STEP_UNV0, STEP_UNV1,
		STEP_UNW, STEP_H, STEP_G0A, STEP_G0B, STEP_G1A, STEP_G1B, STEP_G1C,
		STEP_CBF, STEP_KICK, STEP_D, STEP_A2, STEP_NV, STEP_NW
	} step_t;

	state_t                state_q;
	step_t                 step_q;
	logic [1:0]            term_q;

	// Configuration registers.
	logic signed [23:0]    obs_x_q;
	logic signed [23:0]    obs_y_q;
	logic [20:0]           radius_q;
	logic [20:0]           margin_q;
	logic [16:0]           look_q;
	logic [18:0]           gain_q;

	// Held command.
	logic signed [15:0]    held_lin_q;
	logic signed [18:0]    held_ang_q;

	// Working registers.
	logic signed [23:0]    pos_x_q;
	logic signed [23:0]    pos_y_q;
	logic signed [18:0]    head_q;
	etcbf_pkg::cs_t        c_q;
	etcbf_pkg::cs_t        s_q;
	etcbf_pkg::q_t         px_q, py_q, pdx_q, pdy_q, unv_q, unw_q;
	etcbf_pkg::q_t         dx_q, dy_q, h_q, g0_q, g1_q, d_q;
	etcbf_pkg::op_t        t1_q;
	etcbf_pkg::op_t        num_q;
	etcbf_pkg::op_t        nv_q;
	etcbf_pkg::op_t        nw_q;
	etcbf_pkg::rnd_t       a2_q;
	logic                  trig_q;

	// Pending result and output register.
	logic signed [15:0]    em_lin_q;
	logic signed [18:0]    em_ang_q;
	etcbf_pkg::status_t    em_st_q;
	logic                  out_valid_q;
	logic signed [14:0]    out_lin_q;
	logic signed [18:0]    out_ang_q;
	etcbf_pkg::status_t    out_st_q;

	// Shared units.
	etcbf_pkg::mac_req_t   mac_req;
	etcbf_pkg::op_t        op_a;
	etcbf_pkg::op_t        op_b;
	logic                  op_sub;
	logic [1:0]            last_term;
	etcbf_pkg::acc_t       mac_acc;
	logic                  mac_done;
	logic                  div_start;
	logic [etcbf_pkg::DIV_W-1:0] div_den;
	etcbf_pkg::q_t         div_q;
	logic                  div_done;
	logic                  cor_start;
	etcbf_pkg::cs_t        cor_c;
	etcbf_pkg::cs_t        cor_s;
	logic                  cor_done;

	// Post-processing of the accumulated value.
	etcbf_pkg::op_t        la_op;
	etcbf_pkg::op_t        kp_op;
	etcbf_pkg::op_t        r_op;
	etcbf_pkg::rnd_t       rnd;
	etcbf_pkg::q_t         px_new;
	etcbf_pkg::q_t         py_new;
	etcbf_pkg::q_t         d_new;
	etcbf_pkg::sum_t       cbf;
	logic                  goal_hit;
	logic                  kick;
	logic                  safe;
	logic                  in_xfer;

	assign la_op = etcbf_pkg::op_t'($signed({1'b0, look_q}));
	assign kp_op = etcbf_pkg::op_t'($signed({1'b0, gain_q}));
	assign r_op  = etcbf_pkg::op_t'($signed({1'b0, radius_q}));

	// Product terms of each step.
	always_comb begin
		op_a      = '0;
		op_b      = '0;
		op_sub    = 1'b0;
		last_term = 2'd0;
		unique case (step_q)
			STEP_GOAL: begin
				last_term = 2'd1;
				op_a = (term_q == 2'd0) ? etcbf_pkg::op_t'(pos_x_q) : etcbf_pkg::op_t'(pos_y_q);
				op_b = op_a;
			end
			STEP_PX: begin
				op_a = la_op;
				op_b = etcbf_pkg::op_t'(c_q);
			end
			STEP_PY: begin
				op_a = la_op;
				op_b = etcbf_pkg::op_t'(s_q);
			end
			STEP_PDX: begin
				op_a = kp_op;
				op_b = etcbf_pkg::op_t'(px_q);
			end
			STEP_PDY: begin
				op_a = kp_op;
				op_b = etcbf_pkg::op_t'(py_q);
			end
			STEP_UNV0: begin
				op_a = etcbf_pkg::op_t'(c_q);
				op_b = etcbf_pkg::op_t'(pdx_q);
			end
			STEP_UNV1: begin
				op_a = etcbf_pkg::op_t'(s_q);
				op_b = etcbf_pkg::op_t'(pdy_q);
			end
			STEP_UNW: begin
				last_term = 2'd1;
				if (term_q == 2'd0) begin
					op_a = etcbf_pkg::op_t'(c_q);
					op_b = etcbf_pkg::op_t'(pdy_q);
				end else begin
					op_a   = etcbf_pkg::op_t'(s_q);
					op_b   = etcbf_pkg::op_t'(pdx_q);
					op_sub = 1'b1;
				end
			end
			STEP_H: begin
				last_term = 2'd2;
				if (term_q == 2'd0) begin
					op_a = etcbf_pkg::op_t'(dx_q);
				end else if (term_q == 2'd1) begin
					op_a = etcbf_pkg::op_t'(dy_q);
				end else begin
					op_a   = r_op;
					op_sub = 1'b1;
				end
				op_b = op_a;
			end
			STEP_G0A: begin
				op_a = etcbf_pkg::op_t'(dx_q);
				op_b = etcbf_pkg::op_t'(c_q);
			end
			STEP_G0B: begin
				op_a = etcbf_pkg::op_t'(dy_q);
				op_b = etcbf_pkg::op_t'(s_q);
			end
			STEP_G1A: begin
				op_a = etcbf_pkg::op_t'(dy_q);
				op_b = etcbf_pkg::op_t'(c_q);
			end
			STEP_G1B: begin
				op_a = etcbf_pkg::op_t'(dx_q);
				op_b = etcbf_pkg::op_t'(s_q);
			end
			STEP_G1C: begin
				op_a = la_op;
				op_b = t1_q;
			end
			STEP_CBF: begin
				last_term = 2'd1;
				if (term_q == 2'd0) begin
					op_a = etcbf_pkg::op_t'(g0_q);
					op_b = etcbf_pkg::op_t'(held_lin_q);
				end else begin
					op_a = etcbf_pkg::op_t'(g1_q);
					op_b = etcbf_pkg::op_t'(held_ang_q);
				end
			end
			STEP_KICK: begin
				last_term = 2'd1;
				op_a = (term_q == 2'd0) ? etcbf_pkg::op_t'(held_lin_q)
				                        : etcbf_pkg::op_t'(held_ang_q);
				op_b = op_a;
			end
			STEP_D: begin
				last_term = 2'd1;
				if (term_q == 2'd0) begin
					op_a = etcbf_pkg::op_t'(g0_q);
					op_b = etcbf_pkg::op_t'(unv_q);
				end else begin
					op_a = etcbf_pkg::op_t'(g1_q);
					op_b = etcbf_pkg::op_t'(unw_q);
				end
			end
			STEP_A2: begin
				last_term = 2'd1;
				op_a = (term_q == 2'd0) ? etcbf_pkg::op_t'(g0_q) : etcbf_pkg::op_t'(g1_q);
				op_b = op_a;
			end
			STEP_NV: begin
				op_a = num_q;
				op_b = etcbf_pkg::op_t'(g0_q);
			end
			STEP_NW: begin
				op_a = num_q;
				op_b = etcbf_pkg::op_t'(g1_q);
			end
			default: begin
				op_a = '0;
			end
		endcase
	end

	always_comb begin
		mac_req.start = (state_q == S_ISSUE);
		mac_req.clr   = (term_q == 2'd0);
		mac_req.sub   = op_sub;
	end

	// Rounding and the derived values used when a step completes.
	always_comb begin
		rnd = etcbf_pkg::rnd_t'((mac_acc + etcbf_pkg::acc_t'(etcbf_pkg::HALF_Q))
		                        >>> etcbf_pkg::FRAC_BITS);
		px_new   = etcbf_pkg::sat31(etcbf_pkg::sum_t'(pos_x_q) + etcbf_pkg::sum_t'(rnd));
		py_new   = etcbf_pkg::sat31(etcbf_pkg::sum_t'(pos_y_q) + etcbf_pkg::sum_t'(rnd));
		d_new    = etcbf_pkg::sat31(etcbf_pkg::sum_t'(rnd));
		cbf      = etcbf_pkg::sum_t'(rnd) + etcbf_pkg::sum_t'(h_q);
		goal_hit = mac_acc < etcbf_pkg::acc_t'(etcbf_pkg::GOAL_SQ);
		kick     = mac_acc < etcbf_pkg::acc_t'(etcbf_pkg::KICK_SQ);
		safe     = (etcbf_pkg::sum_t'(d_new) + etcbf_pkg::sum_t'(h_q)) >= 0;
		div_den  = (step_q == STEP_UNW) ? etcbf_pkg::DIV_W'(look_q)
		                                : etcbf_pkg::DIV_W'($unsigned(a2_q));
		div_start = (state_q == S_POST) &&
		            (step_q == STEP_UNW || step_q == STEP_NV || step_q == STEP_NW);
		cor_start = (state_q == S_POST) && (step_q == STEP_GOAL) && !goal_hit;
		in_xfer   = in_valid && (state_q == S_IDLE);
	end

	etcbf_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mac_req),
		.a      (op_a),
		.b      (op_b),
		.acc    (mac_acc),
		.done   (mac_done)
	);

	etcbf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (mac_acc),
		.den    (div_den),
		.quot   (div_q),
		.done   (div_done)
	);

	etcbf_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cor_start),
		.theta  (head_q),
		.cos_q  (cor_c),
		.sin_q  (cor_s),
		.done   (cor_done)
	);

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			obs_x_q  <= 24'sd98304;
			obs_y_q  <= -24'sd6554;
			radius_q <= 21'd32768;
			margin_q <= 21'd6554;
			look_q   <= 17'd9830;
			gain_q   <= 19'd32768;
		end else if (cfg_we) begin
			unique case (cfg_index)
				etcbf_pkg::REG_OBS_X:  obs_x_q  <= cfg_data;
				etcbf_pkg::REG_OBS_Y:  obs_y_q  <= cfg_data;
				etcbf_pkg::REG_RADIUS: radius_q <= cfg_data[20:0];
				etcbf_pkg::REG_MARGIN: margin_q <= cfg_data[20:0];
				etcbf_pkg::REG_LOOK:   look_q   <= cfg_data[16:0];
				etcbf_pkg::REG_GAIN:   gain_q   <= cfg_data[18:0];
				default: begin
				end
			endcase
		end
	end

	// Sequencer control and held command.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= STEP_GOAL;
			term_q      <= 2'd0;
			held_lin_q  <= '0;
			held_ang_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						if (longint'(look_q) < etcbf_pkg::LOOK_MIN) begin
							state_q <= S_EMIT;
						end else begin
							step_q  <= STEP_GOAL;
							term_q  <= 2'd0;
							state_q <= S_ISSUE;
						end
					end
				end
				S_ISSUE: begin
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (mac_done) begin
						if (term_q == last_term) begin
							state_q <= S_POST;
						end else begin
							term_q  <= term_q + 1'b1;
							state_q <= S_ISSUE;
						end
					end
				end
				S_POST: begin
					term_q  <= 2'd0;
					state_q <= S_ISSUE;
					unique case (step_q)
						STEP_GOAL: begin
							if (goal_hit) begin
								held_lin_q <= '0;
								held_ang_q <= '0;
								state_q    <= S_EMIT;
							end else begin
								state_q <= S_CORDIC;
							end
						end
						STEP_PX:   step_q <= STEP_PY;
						STEP_PY:   step_q <= STEP_PDX;
						STEP_PDX:  step_q <= STEP_PDY;
						STEP_PDY:  step_q <= STEP_UNV0;
						STEP_UNV0: step_q <= STEP_UNV1;
						STEP_UNV1: step_q <= STEP_UNW;
						STEP_H:    step_q <= STEP_G0A;
						STEP_G0A:  step_q <= STEP_G0B;
						STEP_G0B:  step_q <= STEP_G1A;
						STEP_G1A:  step_q <= STEP_G1B;
						STEP_G1B:  step_q <= STEP_G1C;
						STEP_G1C:  step_q <= STEP_CBF;
						STEP_CBF:  step_q <= STEP_KICK;
						STEP_KICK: begin
							if (!trig_q && !kick) begin
								state_q <= S_EMIT;
							end else begin
								step_q <= STEP_D;
							end
						end
						STEP_D: begin
							if (safe) begin
								state_q <= S_FIN;
							end else begin
								step_q <= STEP_A2;
							end
						end
						STEP_A2: begin
							if (longint'(rnd) < etcbf_pkg::GRAD_MIN) begin
								state_q <= S_FIN;
							end else begin
								step_q <= STEP_NV;
							end
						end
						STEP_UNW, STEP_NV, STEP_NW: begin
							state_q <= S_DIV;
						end
						default: begin
							state_q <= S_IDLE;
						end
					endcase
				end
				S_CORDIC: begin
					if (cor_done) begin
						step_q  <= STEP_PX;
						term_q  <= 2'd0;
						state_q <= S_ISSUE;
					end
				end
				S_DIV: begin
					if (div_done) begin
						term_q <= 2'd0;
						if (step_q == STEP_UNW) begin
							step_q  <= STEP_H;
							state_q <= S_ISSUE;
						end else if (step_q == STEP_NV) begin
							step_q  <= STEP_NW;
							state_q <= S_ISSUE;
						end else begin
							state_q <= S_FIN;
						end
					end
				end
				S_FIN: begin
					held_lin_q <= 16'(etcbf_pkg::clamp_lim(nv_q, etcbf_pkg::op_t'(etcbf_pkg::VMAX)));
					held_ang_q <= 19'(etcbf_pkg::clamp_lim(nw_q, etcbf_pkg::op_t'(etcbf_pkg::WMAX)));
					state_q    <= S_EMIT;
				end
				S_EMIT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			pos_x_q  <= pos_x;
			pos_y_q  <= pos_y;
			head_q   <= heading;
			em_lin_q <= held_lin_q;
			em_ang_q <= held_ang_q;
			em_st_q  <= etcbf_pkg::STAT_HALT;
		end
		if (state_q == S_CORDIC && cor_done) begin
			c_q <= cor_c;
			s_q <= cor_s;
		end
		if (state_q == S_POST) begin
			unique case (step_q)
				STEP_GOAL: begin
					em_lin_q <= '0;
					em_ang_q <= '0;
					em_st_q  <= etcbf_pkg::STAT_GOAL;
				end
				STEP_PX: begin
					px_q <= px_new;
					dx_q <= etcbf_pkg::sat31(etcbf_pkg::sum_t'(px_new) -
					                         etcbf_pkg::sum_t'(obs_x_q));
				end
				STEP_PY: begin
					py_q <= py_new;
					dy_q <= etcbf_pkg::sat31(etcbf_pkg::sum_t'(py_new) -
					                         etcbf_pkg::sum_t'(obs_y_q));
				end
				STEP_PDX: pdx_q <= etcbf_pkg::sat31(-etcbf_pkg::sum_t'(rnd));
				STEP_PDY: pdy_q <= etcbf_pkg::sat31(-etcbf_pkg::sum_t'(rnd));
				STEP_UNV0, STEP_G0A, STEP_G1A: t1_q <= etcbf_pkg::op_t'(rnd);
				STEP_UNV1: begin
					unv_q <= etcbf_pkg::sat31(etcbf_pkg::sum_t'(t1_q) + etcbf_pkg::sum_t'(rnd));
				end
				STEP_H: h_q <= etcbf_pkg::sat31(etcbf_pkg::sum_t'(rnd));
				STEP_G0B: begin
					g0_q <= etcbf_pkg::sat31((etcbf_pkg::sum_t'(t1_q) +
					                          etcbf_pkg::sum_t'(rnd)) <<< 1);
				end
				STEP_G1B: begin
					t1_q <= etcbf_pkg::op_t'(etcbf_pkg::sat31(etcbf_pkg::sum_t'(t1_q) -
					                                          etcbf_pkg::sum_t'(rnd)));
				end
				STEP_G1C: g1_q <= etcbf_pkg::sat31(etcbf_pkg::sum_t'(rnd) <<< 1);
				STEP_CBF: begin
					trig_q <= cbf < etcbf_pkg::sum_t'($signed({1'b0, margin_q}));
				end
				STEP_KICK: begin
					em_lin_q <= held_lin_q;
					em_ang_q <= held_ang_q;
					em_st_q  <= etcbf_pkg::STAT_HELD;
				end
				STEP_D: begin
					d_q  <= d_new;
					nv_q <= etcbf_pkg::op_t'(unv_q);
					nw_q <= etcbf_pkg::op_t'(unw_q);
				end
				STEP_A2: begin
					a2_q  <= rnd;
					nv_q  <= '0;
					nw_q  <= '0;
					num_q <= etcbf_pkg::op_t'(-etcbf_pkg::sum_t'(h_q) - etcbf_pkg::sum_t'(d_q));
				end
				default: begin
				end
			endcase
		end
		if (state_q == S_DIV && div_done) begin
			if (step_q == STEP_UNW) begin
				unw_q <= div_q;
			end else if (step_q == STEP_NV) begin
				nv_q <= etcbf_pkg::op_t'(etcbf_pkg::sum_t'(unv_q) + etcbf_pkg::sum_t'(div_q));
			end else begin
				nw_q <= etcbf_pkg::op_t'(etcbf_pkg::sum_t'(unw_q) + etcbf_pkg::sum_t'(div_q));
			end
		end
		if (state_q == S_FIN) begin
			em_lin_q <= 16'(etcbf_pkg::clamp_lim(nv_q, etcbf_pkg::op_t'(etcbf_pkg::VMAX)));
			em_ang_q <= 19'(etcbf_pkg::clamp_lim(nw_q, etcbf_pkg::op_t'(etcbf_pkg::WMAX)));
			em_st_q  <= etcbf_pkg::STAT_RECOMP;
		end
		if (state_q == S_EMIT && (!out_valid_q || out_ready)) begin
			out_lin_q <= em_lin_q[14:0];
			out_ang_q <= em_ang_q;
			out_st_q  <= em_st_q;
		end
	end

	assign in_ready         = (state_q == S_IDLE);
	assign out_valid        = out_valid_q;
	assign linear_velocity  = out_lin_q;
	assign angular_velocity = out_ang_q;
	assign status           = out_st_q;

endmodule

/* rtl/core/etcbf_mac.sv */
module etcbf_mac (
	input  logic                clk,
	input  logic                arst_n,
	input  etcbf_pkg::mac_req_t req,
	input  etcbf_pkg::op_t      a,
	input  etcbf_pkg::op_t      b,
	output etcbf_pkg::acc_t     acc,
	output logic                done
);

	logic                                 ph_q;
	logic                                 done_q;
	logic                                 sub_q;
	logic signed [etcbf_pkg::OP_W-etcbf_pkg::LO_W-1:0] a_hi_q;
	etcbf_pkg::op_t                       b_q;
	etcbf_pkg::acc_t                      acc_q;

	logic signed [etcbf_pkg::LO_W:0]      mul_a;
	etcbf_pkg::op_t                       mul_b;
	logic signed [etcbf_pkg::LO_W+etcbf_pkg::OP_W:0] prod;
	etcbf_pkg::acc_t                      term;
	etcbf_pkg::acc_t                      base;
	logic                                 do_sub;

	// One narrow multiplier: low half of a first, then the signed high half.
	always_comb begin
		if (ph_q) begin
			mul_a  = (etcbf_pkg::LO_W+1)'(a_hi_q);
			mul_b  = b_q;
			base   = acc_q;
			do_sub = sub_q;
		end else begin
			mul_a  = $signed({1'b0, a[etcbf_pkg::LO_W-1:0]});
			mul_b  = b;
			base   = req.clr ? '0 : acc_q;
			do_sub = req.sub;
		end
		prod = mul_a * mul_b;
		term = ph_q ? (etcbf_pkg::acc_t'(prod) <<< etcbf_pkg::LO_W)
		            : etcbf_pkg::acc_t'(prod);
	end

	// Partial-product accumulation in two phases, low half then high half.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (ph_q) begin
				ph_q   <= 1'b0;
				done_q <= 1'b1;
			end else if (req.start) begin
				ph_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ph_q || req.start) begin
			acc_q <= do_sub ? (base - term) : (base + term);
		end
		if (req.start && !ph_q) begin
			a_hi_q <= a[etcbf_pkg::OP_W-1:etcbf_pkg::LO_W];
			b_q    <= b;
			sub_q  <= req.sub;
		end
	end

	assign acc  = acc_q;
	assign done = done_q;

endmodule

/* rtl/core/etcbf_div.sv */
module etcbf_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  etcbf_pkg::acc_t                num,
	input  logic [etcbf_pkg::DIV_W-1:0]    den,
	output etcbf_pkg::q_t                  quot,
	output logic                           done
);

	logic                                busy_q;
	logic                                done_q;
	logic                                neg_q;
	logic [$clog2(etcbf_pkg::DIV_W)-1:0] cnt_q;
	logic [etcbf_pkg::DIV_W-1:0]         quo_q;
	logic [etcbf_pkg::DIV_W-1:0]         rem_q;
	logic [etcbf_pkg::DIV_W-1:0]         den_q;

	logic [etcbf_pkg::DIV_W-1:0]         mag;
	logic [etcbf_pkg::DIV_W:0]           rem_sh;
	logic                                fits;
	logic [etcbf_pkg::Q_W-1:0]           q_lim;

	// Magnitude plus half the divisor gives round-to-nearest, ties away from zero.
	always_comb begin
		mag    = etcbf_pkg::DIV_W'(num[etcbf_pkg::ACC_W-1] ? -num : num);
		rem_sh = {rem_q, quo_q[etcbf_pkg::DIV_W-1]};
		fits   = rem_sh >= {1'b0, den_q};
		if (quo_q > etcbf_pkg::DIV_W'(etcbf_pkg::SAT_LIM)) begin
			q_lim = etcbf_pkg::Q_W'(etcbf_pkg::SAT_LIM);
		end else begin
			q_lim = quo_q[etcbf_pkg::Q_W-1:0];
		end
	end

	// Restoring division, one quotient bit per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end else if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			rem_q <= fits ? etcbf_pkg::DIV_W'(rem_sh - {1'b0, den_q})
			              : rem_sh[etcbf_pkg::DIV_W-1:0];
			quo_q <= {quo_q[etcbf_pkg::DIV_W-2:0], fits};
		end else if (start) begin
			rem_q <= '0;
			quo_q <= mag + (den >> 1);
			den_q <= den;
			neg_q <= num[etcbf_pkg::ACC_W-1];
		end
	end

	assign quot = neg_q ? -$signed(q_lim) : $signed(q_lim);
	assign done = done_q;

endmodule

/* rtl/core/etcbf_cordic.sv */
module etcbf_cordic (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic signed [18:0]    theta,
	output etcbf_pkg::cs_t        cos_q,
	output etcbf_pkg::cs_t        sin_q,
	output logic                  done
);

	logic                 busy_q;
	logic                 done_q;
	logic                 neg_q;
	logic [4:0]           it_q;
	etcbf_pkg::op_t       x_q;
	etcbf_pkg::op_t       y_q;
	etcbf_pkg::ang_t      a_q;

	etcbf_pkg::ang_t      a0;
	etcbf_pkg::ang_t      a1;
	etcbf_pkg::ang_t      a2;
	logic                 fold;
	etcbf_pkg::ang_t      at;
	etcbf_pkg::op_t       xs;
	etcbf_pkg::op_t       ys;
	etcbf_pkg::op_t       xr;
	etcbf_pkg::op_t       yr;

	// Reduce the heading to [-pi, pi], then fold into [-pi/2, pi/2].
	always_comb begin
		a0 = etcbf_pkg::ang_t'(theta) <<< etcbf_pkg::CS_SHIFT;
		if (a0 > etcbf_pkg::ANG_PI) begin
			a1 = a0 - etcbf_pkg::ANG_TWO_PI;
		end else if (a0 < -etcbf_pkg::ANG_PI) begin
			a1 = a0 + etcbf_pkg::ANG_TWO_PI;
		end else begin
			a1 = a0;
		end
		fold = 1'b1;
		if (a1 > etcbf_pkg::ANG_HALF_PI) begin
			a2 = a1 - etcbf_pkg::ANG_PI;
		end else if (a1 < -etcbf_pkg::ANG_HALF_PI) begin
			a2 = a1 + etcbf_pkg::ANG_PI;
		end else begin
			a2   = a1;
			fold = 1'b0;
		end
	end

	// One micro-rotation per cycle.
	always_comb begin
		at = etcbf_pkg::ang_t'($signed({1'b0, etcbf_pkg::ATAN_TAB[it_q]}));
		xs = x_q >>> it_q;
		ys = y_q >>> it_q;
		xr = (x_q + etcbf_pkg::op_t'(1 <<< (etcbf_pkg::CS_SHIFT - 1)))
		     >>> etcbf_pkg::CS_SHIFT;
		yr = (y_q + etcbf_pkg::op_t'(1 <<< (etcbf_pkg::CS_SHIFT - 1)))
		     >>> etcbf_pkg::CS_SHIFT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			it_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (busy_q) begin
				if (it_q == 5'(etcbf_pkg::CORDIC_N - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					it_q <= it_q + 1'b1;
				end
			end else if (start) begin
				busy_q <= 1'b1;
				it_q   <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			if (a_q >= 0) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				a_q <= a_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				a_q <= a_q + at;
			end
		end else if (start) begin
			x_q   <= etcbf_pkg::CORDIC_GAIN;
			y_q   <= '0;
			a_q   <= a2;
			neg_q <= fold;
		end
	end

	assign cos_q = etcbf_pkg::cs_t'(neg_q ? -xr : xr);
	assign sin_q = etcbf_pkg::cs_t'(neg_q ? -yr : yr);
	assign done  = done_q;

endmodule

/* rtl/core/etcbf_checker.sv */
module etcbf_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [14:0] linear_velocity,
	input logic signed [18:0] angular_velocity,
	input logic [1:0]         status
);

	// A stalled result holds until its transfer.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(linear_velocity) &&
		$stable(angular_velocity) && $stable(status))
		else $error("stalled result changed");

	// Every pose needs work outside the idle state, so ready drops after a transfer.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken twice in a row");

	// A goal result carries a zero command.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == etcbf_pkg::STAT_GOAL |->
		linear_velocity == '0 && angular_velocity == '0)
		else $error("goal result with nonzero command");

	// The command never leaves the speed limits.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> linear_velocity <= 15'sd14418 && linear_velocity >= -15'sd14418 &&
		angular_velocity <= 19'sd186122 && angular_velocity >= -19'sd186122)
		else $error("command outside limits");

endmodule

bind event_triggered_cbf_unicycle_top etcbf_checker u_etcbf_checker (.*);

/* tb/event_triggered_cbf_unicycle_checker.sv */
module event_triggered_cbf_unicycle_checker
	import etcbf_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic signed [23:0] pos_x,
	input  logic signed [23:0] pos_y,
	input  logic signed [18:0] heading,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic signed [14:0] linear_velocity,
	input  logic signed [18:0] angular_velocity,
	input  logic [1:0]         status,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [23:0]        cfg_data,
	output int                 errors,
	output int                 pending
);

	typedef struct {
		logic signed [14:0] lin;
		logic signed [18:0] ang;
		status_t            st;
	} command_t;

	command_t   cmd_q[$];
	logic [23:0] regs[6];
	longint     hold_v;
	longint     hold_w;

	assign pending = cmd_q.size();

	function automatic longint clip(input longint v, input longint lim);
		if (v > lim) return lim;
		if (v < -lim) return -lim;
		return v;
	endfunction

	function automatic longint fx_mul(input longint a, input longint b);
		return (a * b + HALF_Q) >>> FRAC_BITS;
	endfunction

	function automatic longint rdiv(input longint n, input longint d);
		longint m;
		longint q;
		m = (n < 0) ? -n : n;
		q = (m + d / 2) / d;
		return (n < 0) ? -q : q;
	endfunction

	// Sine and cosine of a Q16.16 angle via the Q2.30 rotation CORDIC.
	function automatic void trig(input longint th, output longint c, output longint s);
		longint a;
		longint cx;
		longint cy;
		longint nx;
		bit     flip;
		a = th * (longint'(1) << CS_SHIFT);
		cx = CORDIC_GAIN;
		cy = 0;
		flip = 0;
		while (a > ANG_PI) a -= ANG_TWO_PI;
		while (a < -ANG_PI) a += ANG_TWO_PI;
		if (a > ANG_HALF_PI) begin
			a -= ANG_PI;
			flip = 1;
		end else if (a < -ANG_HALF_PI) begin
			a += ANG_PI;
			flip = 1;
		end
		for (int i = 0; i < CORDIC_N; i++) begin
			if (a >= 0) begin
				nx = cx - (cy >>> i);
				cy = cy + (cx >>> i);
				a -= longint'(ATAN_TAB[i]);
			end else begin
				nx = cx + (cy >>> i);
				cy = cy - (cx >>> i);
				a += longint'(ATAN_TAB[i]);
			end
			cx = nx;
		end
		cx = (cx + (longint'(1) << (CS_SHIFT - 1))) >>> CS_SHIFT;
		cy = (cy + (longint'(1) << (CS_SHIFT - 1))) >>> CS_SHIFT;
		c = flip ? -cx : cx;
		s = flip ? -cy : cy;
	endfunction

	// Next command for one pose; updates the held command.
	function automatic command_t steer(input longint x, input longint y, input longint th);
		command_t r;
		longint ox, oy, rad, eps, la, kp;
		longint c, s, px, py, pdx, pdy, unv, unw, dx, dy, h, g0, g1, bar, d, a2, num, nv, nw;
		ox = longint'(signed'(regs[REG_OBS_X]));
		oy = longint'(signed'(regs[REG_OBS_Y]));
		rad = longint'(regs[REG_RADIUS][20:0]);
		eps = longint'(regs[REG_MARGIN][20:0]);
		la = longint'(regs[REG_LOOK][16:0]);
		kp = longint'(regs[REG_GAIN][18:0]);
		if (la < LOOK_MIN) begin
			r.lin = 15'(hold_v);
			r.ang = 19'(hold_w);
			r.st = STAT_HALT;
			return r;
		end
		if (x * x + y * y < GOAL_SQ) begin
			hold_v = 0;
			hold_w = 0;
			r.lin = '0;
			r.ang = '0;
			r.st = STAT_GOAL;
			return r;
		end
		trig(th, c, s);
		px = clip(x + fx_mul(la, c), SAT_LIM);
		py = clip(y + fx_mul(la, s), SAT_LIM);
		pdx = clip(-fx_mul(kp, px), SAT_LIM);
		pdy = clip(-fx_mul(kp, py), SAT_LIM);
		unv = clip(fx_mul(c, pdx) + fx_mul(s, pdy), SAT_LIM);
		unw = clip(rdiv(c * pdy - s * pdx, la), SAT_LIM);
		dx = clip(px - ox, SAT_LIM);
		dy = clip(py - oy, SAT_LIM);
		h = clip((dx * dx + dy * dy - rad * rad + HALF_Q) >>> FRAC_BITS, SAT_LIM);
		g0 = clip(2 * (fx_mul(dx, c) + fx_mul(dy, s)), SAT_LIM);
		g1 = clip(2 * fx_mul(la, clip(fx_mul(dy, c) - fx_mul(dx, s), SAT_LIM)), SAT_LIM);
		bar = ((g0 * hold_v + g1 * hold_w + HALF_Q) >>> FRAC_BITS) + h;
		if (!(bar < eps) && !(hold_v * hold_v + hold_w * hold_w < KICK_SQ)) begin
			r.lin = 15'(hold_v);
			r.ang = 19'(hold_w);
			r.st = STAT_HELD;
			return r;
		end
		d = clip((g0 * unv + g1 * unw + HALF_Q) >>> FRAC_BITS, SAT_LIM);
		if (d >= -h) begin
			nv = unv;
			nw = unw;
		end else begin
			a2 = (g0 * g0 + g1 * g1 + HALF_Q) >>> FRAC_BITS;
			if (a2 < GRAD_MIN) begin
				nv = 0;
				nw = 0;
			end else begin
				num = -h - d;
				nv = unv + clip(rdiv(num * g0, a2), SAT_LIM);
				nw = unw + clip(rdiv(num * g1, a2), SAT_LIM);
			end
		end
		hold_v = clip(nv, VMAX);
		hold_w = clip(nw, WMAX);
		r.lin = 15'(hold_v);
		r.ang = 19'(hold_w);
		r.st = STAT_RECOMP;
		return r;
	endfunction

	// Track register writes, predict on each pose transfer, compare each result transfer.
	always @(posedge clk or negedge arst_n) begin
		command_t exp_cmd;
		int       fails;
		if (!arst_n) begin
			regs[REG_OBS_X] <= 24'(98304);
			regs[REG_OBS_Y] <= 24'(-6554);
			regs[REG_RADIUS] <= 24'(32768);
			regs[REG_MARGIN] <= 24'(6554);
			regs[REG_LOOK] <= 24'(9830);
			regs[REG_GAIN] <= 24'(32768);
			hold_v = 0;
			hold_w = 0;
			errors <= 0;
			cmd_q.delete();
		end else begin
			fails = 0;
			if (cfg_we && cfg_index < 6) begin
				regs[cfg_index] <= cfg_data;
			end
			if (out_valid && out_ready) begin
				if (cmd_q.size() == 0) begin
					$error("result transfer with no pose pending");
					fails++;
				end else begin
					exp_cmd = cmd_q.pop_front();
					if (linear_velocity !== exp_cmd.lin) begin
						$error("linear_velocity: expected %0d, got %0d",
							exp_cmd.lin, linear_velocity);
						fails++;
					end
					if (angular_velocity !== exp_cmd.ang) begin
						$error("angular_velocity: expected %0d, got %0d",
							exp_cmd.ang, angular_velocity);
						fails++;
					end
					if (status !== exp_cmd.st) begin
						$error("status: expected %0d, got %0d", exp_cmd.st, status);
						fails++;
					end
				end
			end
			if (fails != 0) begin
				errors <= errors + fails;
			end
			if (in_valid && in_ready) begin
				cmd_q.push_back(steer(pos_x, pos_y, heading));
			end
		end
	end

endmodule

/* tb/event_triggered_cbf_unicycle_top_tb.sv */
module event_triggered_cbf_unicycle_top_tb;
	import etcbf_pkg::*;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic signed [23:0] pos_x;
	logic signed [23:0] pos_y;
	logic signed [18:0] heading;
	logic               out_valid;
	logic               out_ready;
	logic signed [14:0] linear_velocity;
	logic signed [18:0] angular_velocity;
	logic [1:0]         status;
	logic               cfg_we;
	logic [2:0]         cfg_index;
	logic [23:0]        cfg_data;
	int                 errors;
	int                 pending;
	int                 snd_idle;
	int                 rcv_idle;
	int                 poses_sent;

	// Obstacle x, obstacle y, radius, margin, lookahead, gain per phase.
	int setups[6][6] = '{
		'{98304, -6554, 32768, 6554, 9830, 32768},
		'{65536, 0, 1048576, 1048576, 65536, 262144},
		'{-8388608, 8388607, 0, 0, 1, 0},
		'{0, 0, 65536, 0, 0, 65536},
		'{8388607, -8388608, 16384, 1048576, 32768, 131072},
		'{32768, 32768, 49152, 13107, 16384, 65536}
	};

	event_triggered_cbf_unicycle_top dut (.*);

	event_triggered_cbf_unicycle_checker chk (.*);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Receiver stalls at random.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= rcv_idle);
	end

	initial begin
		#(12 * 3000000);
		$display("end of test: mismatches");
		$finish;
	end

	// Offer one pose, with an optional gap before it, and wait for its transfer.
	task automatic send_pose(input int px, input int py, input int hd);
		if ($urandom_range(99) < snd_idle) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		pos_x <= 24'(px);
		pos_y <= 24'(py);
		heading <= 19'(hd);
		in_valid <= 1'b1;
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
		poses_sent++;
	endtask

	// Drain all results, let the block settle, then load one register setup.
	task automatic load_setup(input int p);
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (400) @(posedge clk);
		for (int i = 0; i < 6; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= 3'(i);
			cfg_data <= 24'(setups[p][i]);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	initial begin
		int sel;
		int px;
		int py;
		int hd;
		in_valid <= 1'b0;
		out_ready <= 1'b0;
		pos_x <= '0;
		pos_y <= '0;
		heading <= '0;
		cfg_we <= 1'b0;
		cfg_index <= REG_OBS_X;
		cfg_data <= '0;
		snd_idle = 35;
		rcv_idle = 51;
		poses_sent = 0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed poses under the reset setup: goal edge, extremes, heading wrap.
		send_pose(0, 0, 0);
		send_pose(3276, 0, 0);
		send_pose(3277, 0, 0);
		send_pose(8388607, 8388607, 205887);
		send_pose(-8388608, -8388608, -205887);
		send_pose(8388607, -8388608, 262143);
		send_pose(-8388608, 8388607, -262144);
		send_pose(65536, 0, 0);
		send_pose(131072, -6554, 205887);
		send_pose(0, 65536, 102943);
		send_pose(-65536, -65536, -102944);
		send_pose(98304, -40000, 0);
		send_pose(196608, 0, 205887);
		send_pose(200000, 30000, 160000);

		// Random poses over every setup, with the idle pattern shifting by thirds.
		for (int p = 0; p < 6; p++) begin
			load_setup(p);
			for (int k = 0; k < 170; k++) begin
				if (poses_sent > 680) begin
					snd_idle = 0;
					rcv_idle = 0;
				end else if (poses_sent > 350) begin
					snd_idle = 51;
					rcv_idle = 35;
				end
				sel = $urandom_range(99);
				if (sel < 60) begin
					px = $urandom_range(524288) - 262144;
					py = $urandom_range(524288) - 262144;
				end else if (sel < 75) begin
					px = $urandom_range(8000) - 4000;
					py = $urandom_range(8000) - 4000;
				end else begin
					px = $urandom_range(16777215) - 8388608;
					py = $urandom_range(16777215) - 8388608;
				end
				if ($urandom_range(9) == 0) begin
					hd = $urandom_range(524287) - 262144;
				end else begin
					hd = $urandom_range(411774) - 205887;
				end
				send_pose(px, py, hd);
			end
		end

		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (400) @(posedge clk);
		$display("Sent %0d poses over six obstacle and gain setups,", poses_sent);
		$display("including halted, goal and extreme-range poses, under varied stalls.");
		if (errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

/* sim.f */
rtl/core/etcbf_pkg.sv
rtl/core/etcbf_mac.sv
rtl/core/etcbf_div.sv
rtl/core/etcbf_cordic.sv
rtl/core/event_triggered_cbf_unicycle_top.sv
rtl/core/etcbf_checker.sv
tb/event_triggered_cbf_unicycle_checker.sv
tb/event_triggered_cbf_unicycle_top_tb.sv
